// ----- design/lbfs_pkg.sv -----
// Shared types, codes and the channel order table for the LED bit-plane frame store.
// Used by the configuration, datapath and top modules; it depends on nothing else.
package lbfs_pkg;

  // Layout of one pixel row: three output slots of eight bit planes each.
  localparam int NUM_SLOTS  = 3;
  localparam int NUM_PLANES = 8;
  localparam int WORDS_PER_PIXEL = NUM_SLOTS * NUM_PLANES;

  // Item operations.
  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_SHOW  = 2'd2,
    MODE_PLANE = 2'd3
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_STRING_COUNT  = 2'd0,
    CFG_PIXEL_COUNT   = 2'd1,
    CFG_CHANNEL_ORDER = 2'd2,
    CFG_BOARD_COUNT   = 2'd3
  } cfg_index_t;

  // Channel orders; the two unused codes behave as GRB.
  typedef enum logic [2:0] {
    ORD_GRB = 3'd0,
    ORD_RGB = 3'd1,
    ORD_BGR = 3'd2,
    ORD_RBG = 3'd3,
    ORD_GBR = 3'd4,
    ORD_BRG = 3'd5
  } order_t;

  // Color components of the RGB input word.
  localparam logic [1:0] COMP_RED   = 2'd0;
  localparam logic [1:0] COMP_GREEN = 2'd1;
  localparam logic [1:0] COMP_BLUE  = 2'd2;

  // Channel slot used by the plane read that holds no data.
  localparam logic [1:0] SLOT_NONE = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [5:0] STRING_COUNT_RST  = 6'd32;
  localparam logic [9:0] PIXEL_COUNT_RST   = 10'd512;
  localparam logic [2:0] CHANNEL_ORDER_RST = 3'd0;
  localparam logic [7:0] BOARD_COUNT_RST   = 8'd1;

  // Current configuration as seen by the datapath.
  typedef struct packed {
    logic [5:0] string_count;
    logic [9:0] pixel_count;
    logic [2:0] channel_order;
    logic [7:0] board_count;
  } cfg_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS
  } state_t;

  // Component held by each slot, packed as {slot 2, slot 1, slot 0}.
  function automatic logic [5:0] slot_sources(input logic [2:0] order);
    logic [5:0] src;
    case (order)
      ORD_RGB: src = {COMP_BLUE,  COMP_GREEN, COMP_RED};
      ORD_BGR: src = {COMP_RED,   COMP_GREEN, COMP_BLUE};
      ORD_RBG: src = {COMP_GREEN, COMP_BLUE,  COMP_RED};
      ORD_GBR: src = {COMP_RED,   COMP_BLUE,  COMP_GREEN};
      ORD_BRG: src = {COMP_GREEN, COMP_RED,   COMP_BLUE};
      default: src = {COMP_BLUE,  COMP_RED,   COMP_GREEN};
    endcase
    return src;
  endfunction

endpackage

// ----- design/lbfs_cfg_regs.sv -----
// Configuration registers of the LED bit-plane frame store.
// Depends on lbfs_pkg for the register indexes, reset values and cfg_t.
module lbfs_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [9:0]          cfg_wdata,
  output lbfs_pkg::cfg_t      cfg
);

  lbfs_pkg::cfg_t cfg_r;

  // Decode the register index and capture the low bits of the write data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.string_count  <= lbfs_pkg::STRING_COUNT_RST;
      cfg_r.pixel_count   <= lbfs_pkg::PIXEL_COUNT_RST;
      cfg_r.channel_order <= lbfs_pkg::CHANNEL_ORDER_RST;
      cfg_r.board_count   <= lbfs_pkg::BOARD_COUNT_RST;
    end else if (cfg_we) begin
      case (lbfs_pkg::cfg_index_t'(cfg_index))
        lbfs_pkg::CFG_STRING_COUNT:  cfg_r.string_count  <= cfg_wdata[5:0];
        lbfs_pkg::CFG_PIXEL_COUNT:   cfg_r.pixel_count   <= cfg_wdata[9:0];
        lbfs_pkg::CFG_CHANNEL_ORDER: cfg_r.channel_order <= cfg_wdata[2:0];
        lbfs_pkg::CFG_BOARD_COUNT:   cfg_r.board_count   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- design/lbfs_plane_mem.sv -----
// Pixel row memory: one row holds all plane words of one pixel of one buffer.
// One write port and one read port with registered read data; no package use.
module lbfs_plane_mem #(
  parameter int WIDTH = 768,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, with registered read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/lbfs_row_ops.sv -----
// Row datapath: updates one string's bit in all plane words of a pixel row,
// rebuilds the RGB color of that string and selects one plane word. Uses lbfs_pkg.
module lbfs_row_ops #(
  parameter int MAX_STRINGS = 32
) (
  input  logic [lbfs_pkg::WORDS_PER_PIXEL*MAX_STRINGS-1:0] row,
  input  logic [4:0]                                       str,
  input  logic [23:0]                                      rgb,
  input  logic [2:0]                                       order,
  input  logic [1:0]                                       chan,
  input  logic [2:0]                                       plane,
  output logic [lbfs_pkg::WORDS_PER_PIXEL*MAX_STRINGS-1:0] new_row,
  output logic [23:0]                                      color,
  output logic [MAX_STRINGS-1:0]                           word
);

  localparam int WPP = lbfs_pkg::WORDS_PER_PIXEL;
  localparam int NP  = lbfs_pkg::NUM_PLANES;

  logic [31:0]            mask32;
  logic [MAX_STRINGS-1:0] mask;
  logic [5:0]             src_all;
  logic [7:0]             slot_val [lbfs_pkg::NUM_SLOTS];
  logic [7:0]             slot_rd  [lbfs_pkg::NUM_SLOTS];
  logic [1:0]             src      [lbfs_pkg::NUM_SLOTS];
  logic [MAX_STRINGS-1:0] old_word;
  logic [4:0]             sel;

  assign mask32  = 32'd1 << str;
  assign mask    = mask32[MAX_STRINGS-1:0];
  assign src_all = lbfs_pkg::slot_sources(order);

  // Pick the color byte that feeds each slot.
  always_comb begin
    for (int ch = 0; ch < lbfs_pkg::NUM_SLOTS; ch++) begin
      src[ch] = src_all[2*ch +: 2];
      case (src[ch])
        lbfs_pkg::COMP_RED:   slot_val[ch] = rgb[23:16];
        lbfs_pkg::COMP_GREEN: slot_val[ch] = rgb[15:8];
        default:              slot_val[ch] = rgb[7:0];
      endcase
    end
  end

  // Set or clear the string's bit in every plane word, MSB in plane 0,
  // and gather the string's stored bits at the same time.
  always_comb begin
    new_row  = row;
    old_word = '0;
    for (int ch = 0; ch < lbfs_pkg::NUM_SLOTS; ch++) begin
      slot_rd[ch] = '0;
      for (int b = 0; b < NP; b++) begin
        old_word = row[(ch*NP + b)*MAX_STRINGS +: MAX_STRINGS];
        new_row[(ch*NP + b)*MAX_STRINGS +: MAX_STRINGS] =
          slot_val[ch][NP-1-b] ? (old_word | mask) : (old_word & ~mask);
        slot_rd[ch][NP-1-b] = |(old_word & mask);
      end
    end
  end

  // Put each slot's byte back at its color position.
  always_comb begin
    color = '0;
    for (int ch = 0; ch < lbfs_pkg::NUM_SLOTS; ch++) begin
      case (src[ch])
        lbfs_pkg::COMP_RED:   color[23:16] = slot_rd[ch];
        lbfs_pkg::COMP_GREEN: color[15:8]  = slot_rd[ch];
        default:              color[7:0]   = slot_rd[ch];
      endcase
    end
  end

  // Plane word select; the empty slot matches no word.
  assign sel = {chan, plane};
  always_comb begin
    word = '0;
    for (int w = 0; w < WPP; w++) begin
      if (chan != lbfs_pkg::SLOT_NONE && 5'(w) == 5'(int'(chan) * NP + int'(plane))) begin
        word = row[w*MAX_STRINGS +: MAX_STRINGS];
      end
    end
    if (sel == '1) begin
      word = '0;
    end
  end

endmodule

// ----- design/led_bitplane_frame_store.sv -----
// Top level of the double-buffered LED bit-plane frame store.
// Depends on lbfs_pkg, lbfs_cfg_regs, lbfs_plane_mem and lbfs_row_ops.
//
//   Channel   Ports      Handshake      Carries
//   input     in_*       valid/ready    mode, board, string, pixel, color, slot, plane, busy
//   result    out_*      valid/ready    color, plane word, accepted, back buffer, frames
//   config    cfg_*      write enable   register index and data, no read-back
//
// The row of each item's pixel is read from the row memory in the accept cycle
// and modified and written back, with its result formed, in the next; no new
// item is accepted until then. A result waits in a holding register until the
// output register frees, so one further item is accepted while a result stalls.
// After reset a clearing pass zeroes all 2*PIXELS_PER_STRING rows of the
// memory, one row a cycle, before the first item is taken.
module led_bitplane_frame_store #(
  parameter int PIXELS_PER_STRING = 512,
  parameter int MAX_STRINGS       = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_board,
  input  logic [4:0]  in_string_index,
  input  logic [8:0]  in_pixel_index,
  input  logic [23:0] in_rgb_color,
  input  logic [1:0]  in_channel,
  input  logic [2:0]  in_plane,
  input  logic        in_output_busy,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_read_color,
  output logic [31:0] out_plane_word,
  output logic        out_accepted,
  output logic        out_back_select,
  output logic [31:0] out_frames_shown,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_wdata
);

  localparam int DEPTH = 2 * PIXELS_PER_STRING;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = lbfs_pkg::WORDS_PER_PIXEL * MAX_STRINGS;

  lbfs_pkg::cfg_t   cfg;
  lbfs_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]  clr_cnt_r;
  logic           accept;
  logic           pix_ok, item_ok, plane_ok, ok;
  logic           buf_sel;
  logic [31:0]    addr_full;
  logic [AW-1:0]  rd_addr;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [RW-1:0]  wr_data;
  logic [RW-1:0]  rd_data;
  logic [RW-1:0]  new_row;
  logic [23:0]    row_color;
  logic [MAX_STRINGS-1:0] row_word;

  // Latched item.
  lbfs_pkg::mode_t item_mode_r;
  logic           item_ok_r;
  logic           item_busy_r;
  logic [4:0]     item_str_r;
  logic [23:0]    item_rgb_r;
  logic [1:0]     item_chan_r;
  logic [2:0]     item_plane_r;
  logic [AW-1:0]  item_addr_r;

  // Buffer state.
  logic           back_r;
  logic [31:0]    frames_r;
  logic           show_ok;

  // Holding and output registers.
  logic           res_valid_r;
  logic [23:0]    res_color_r;
  logic [31:0]    res_word_r;
  logic           res_acc_r;
  logic           res_back_r;
  logic [31:0]    res_frames_r;
  logic           out_valid_r;
  logic [23:0]    out_color_r;
  logic [31:0]    out_word_r;
  logic           out_acc_r;
  logic           out_back_r;
  logic [31:0]    out_frames_r;
  logic           out_load;

  lbfs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Range checks, taken at accept while the configuration is stable.
  assign pix_ok  = ({1'b0, in_pixel_index} < cfg.pixel_count) &&
                   ({23'd0, in_pixel_index} < 32'(PIXELS_PER_STRING));
  assign item_ok = (in_board < cfg.board_count) &&
                   ({1'b0, in_string_index} < cfg.string_count) &&
                   ({27'd0, in_string_index} < 32'(MAX_STRINGS)) && pix_ok;
  assign plane_ok = pix_ok && (in_channel != lbfs_pkg::SLOT_NONE);

  always_comb begin
    case (lbfs_pkg::mode_t'(in_mode))
      lbfs_pkg::MODE_WRITE,
      lbfs_pkg::MODE_READ:  ok = item_ok;
      lbfs_pkg::MODE_PLANE: ok = plane_ok;
      default:              ok = 1'b0;
    endcase
  end

  // Row address: plane reads use the front buffer, everything else the back.
  assign buf_sel   = (lbfs_pkg::mode_t'(in_mode) == lbfs_pkg::MODE_PLANE) ? ~back_r : back_r;
  assign addr_full = (buf_sel ? 32'(PIXELS_PER_STRING) : 32'd0) + {23'd0, in_pixel_index};
  assign rd_addr   = ok ? addr_full[AW-1:0] : '0;

  // A new item may be accepted in the cycle the holding register hands its result on.
  assign in_ready = (state_r == lbfs_pkg::ST_IDLE) && (!res_valid_r || out_load);
  assign accept   = in_valid && in_ready;

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= lbfs_pkg::ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == lbfs_pkg::ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  // Next state and memory write control.
  always_comb begin
    state_nxt = state_r;
    wr_en     = 1'b0;
    wr_addr   = item_addr_r;
    wr_data   = new_row;
    case (state_r)
      lbfs_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_r;
        wr_data = '0;
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = lbfs_pkg::ST_IDLE;
        end
      end
      lbfs_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = lbfs_pkg::ST_ACCESS;
        end
      end
      lbfs_pkg::ST_ACCESS: begin
        wr_en     = (item_mode_r == lbfs_pkg::MODE_WRITE) && item_ok_r;
        state_nxt = lbfs_pkg::ST_IDLE;
      end
      default: state_nxt = lbfs_pkg::ST_IDLE;
    endcase
  end

  lbfs_plane_mem #(
    .WIDTH (RW),
    .DEPTH (DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lbfs_row_ops #(
    .MAX_STRINGS (MAX_STRINGS)
  ) u_ops (
    .row     (rd_data),
    .str     (item_str_r),
    .rgb     (item_rgb_r),
    .order   (cfg.channel_order),
    .chan    (item_chan_r),
    .plane   (item_plane_r),
    .new_row (new_row),
    .color   (row_color),
    .word    (row_word)
  );

  // Capture the item at accept.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_mode_r  <= lbfs_pkg::mode_t'(in_mode);
      item_ok_r    <= ok;
      item_busy_r  <= in_output_busy;
      item_str_r   <= in_string_index;
      item_rgb_r   <= in_rgb_color;
      item_chan_r  <= in_channel;
      item_plane_r <= in_plane;
      item_addr_r  <= rd_addr;
    end
  end

  assign show_ok = (state_r == lbfs_pkg::ST_ACCESS) &&
                   (item_mode_r == lbfs_pkg::MODE_SHOW) && !item_busy_r;

  // Buffer swap and frame count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      back_r   <= 1'b0;
      frames_r <= '0;
    end else if (show_ok) begin
      back_r   <= ~back_r;
      frames_r <= frames_r + 32'd1;
    end
  end

  // Form the result into the holding register.
  always_ff @(posedge clk) begin
    if (state_r == lbfs_pkg::ST_ACCESS) begin
      res_color_r  <= (item_mode_r == lbfs_pkg::MODE_READ && item_ok_r) ? row_color : 24'd0;
      res_word_r   <= (item_mode_r == lbfs_pkg::MODE_PLANE && item_ok_r) ?
                      32'(row_word) : 32'd0;
      res_acc_r    <= (item_mode_r == lbfs_pkg::MODE_SHOW) ? !item_busy_r : item_ok_r;
      res_back_r   <= show_ok ? ~back_r : back_r;
      res_frames_r <= show_ok ? frames_r + 32'd1 : frames_r;
    end
  end

  assign out_load = res_valid_r && (!out_valid_r || out_ready);

  // Holding register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (state_r == lbfs_pkg::ST_ACCESS) begin
      res_valid_r <= 1'b1;
    end else if (out_load) begin
      res_valid_r <= 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_color_r  <= res_color_r;
      out_word_r   <= res_word_r;
      out_acc_r    <= res_acc_r;
      out_back_r   <= res_back_r;
      out_frames_r <= res_frames_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_color   = out_color_r;
  assign out_plane_word   = out_word_r;
  assign out_accepted     = out_acc_r;
  assign out_back_select  = out_back_r;
  assign out_frames_shown = out_frames_r;

endmodule
